>>> hw/rtl/mss_pkg.sv
// Package: shared types, codes and default sizes for the MPEG stream sniffer.
`default_nettype none

package mss_pkg;

  localparam int LOOKAHEAD_BYTES_DEF = 40;
  localparam int GARBAGE_LIMIT_DEF   = 1024;
  localparam int POSITION_BITS_DEF   = 36;
  localparam int OFFSET_W            = 36;

  typedef enum logic [2:0] {
    VERDICT_NONE    = 3'd0,
    VERDICT_BAD_ID3 = 3'd1,
    VERDICT_GARBAGE = 3'd2,
    VERDICT_START   = 3'd3,
    VERDICT_MP3     = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          verdict;
    logic [OFFSET_W-1:0] decision_offset;
  } out_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/mss_stream_if.sv
// Interface: valid/ready channel that carries one word per handshake.
`default_nettype none

interface mss_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mpeg_stream_sniffer.sv
// Top level: byte-serial MPEG stream detector (ID3 skip, system start code, layer-III header).
//
//  channel   | dir | word             | handshake
//  ----------+-----+------------------+-------------------------------------------
//  in_chan   | in  | data_byte,is_last| valid && ready, one file byte per word
//  out_chan  | out | verdict,offset   | valid && ready, one word per is_last byte
//
// Flow: one byte is taken every cycle unless a stall holds the input register;
//   each byte is registered in the input register, then the window, counters
//   and verdict update when it advances. The result word of a file is
//   registered in the output register as its last byte advances.
// Reset: synchronous, active low; clears counters, verdict and both valid flags.
// Stalls: only a last byte waiting on a full, unread output register holds the
//   input register; every other byte advances regardless of out_chan.ready.
`default_nettype none

module mpeg_stream_sniffer #(
  parameter int LOOKAHEAD_BYTES = mss_pkg::LOOKAHEAD_BYTES_DEF,
  parameter int GARBAGE_LIMIT   = mss_pkg::GARBAGE_LIMIT_DEF,
  parameter int POSITION_BITS   = mss_pkg::POSITION_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mss_stream_if.sink   in_chan,
  mss_stream_if.source out_chan
);

  localparam int PB     = POSITION_BITS;
  localparam int MISS_W = $clog2(GARBAGE_LIMIT + 1);
  localparam int OW     = mss_pkg::OFFSET_W;

  // Valid layer-III frame header: sync, version, layer, bitrate, rate, emphasis.
  function automatic logic frame_ok(input logic [31:0] w);
    logic ok;
    ok = 1'b1;
    if ((w & 32'hffe00000) != 32'hffe00000) ok = 1'b0;
    if ((w & 32'h00180000) == 32'h00080000) ok = 1'b0;
    if ((w & 32'h00060000) != 32'h00020000) ok = 1'b0;
    if ((w & 32'h0000f000) == 32'h00000000) ok = 1'b0;
    if ((w & 32'h0000f000) == 32'h0000f000) ok = 1'b0;
    if ((w & 32'h00000c00) == 32'h00000c00) ok = 1'b0;
    if ((w & 32'h00000003) == 32'h00000002) ok = 1'b0;
    return ok;
  endfunction

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Byte window: dl_r[i] sits LOOKAHEAD_BYTES - i behind the newest byte kept;
  // the oldest one drops out as each new byte shifts in.
  logic [7:0] dl_r [1:LOOKAHEAD_BYTES];
  logic [7:0] win  [0:LOOKAHEAD_BYTES];

  // Scan state
  logic [PB-1:0]     cur_r, cur_nxt;
  logic [PB-1:0]     next_r, next_nxt;
  logic [MISS_W-1:0] miss_r, miss_nxt;
  mss_pkg::verdict_t dec_v_r, dec_v_nxt;
  logic [PB-1:0]     dec_off_r, dec_off_nxt;

  // Output register
  logic              out_vld_r;
  mss_pkg::verdict_t out_verdict_r;
  logic [OW-1:0]     out_off_r;

  logic adv;
  logic in_rdy;

  // Hold the registered byte only when it closes a file and the result slot is busy.
  assign adv    = in_vld_r && !(in_last_r && out_vld_r && !out_chan.ready);
  assign in_rdy = !in_vld_r || adv;
  assign in_chan.ready = in_rdy;

  // Window as it looks once the registered byte has shifted in.
  always_comb begin
    for (int i = 0; i <= LOOKAHEAD_BYTES; i++) begin
      if (i < LOOKAHEAD_BYTES) begin
        win[i] = dl_r[i+1];
      end else begin
        win[i] = in_byte_r;
      end
    end
  end

  logic [31:0]   word;
  logic          is_id3;
  logic          bad_size;
  logic [27:0]   size7;
  logic          is_start;
  logic          is_frame;
  logic [PB-1:0] pos;
  logic          exam_en;
  logic          miss_chk;
  logic [PB+OW-1:0] off_wide;

  assign word     = {win[0], win[1], win[2], win[3]};
  assign is_id3   = (word[31:8] == 24'h494433);
  assign bad_size = win[6][7] | win[7][7] | win[8][7] | win[9][7];
  assign size7    = {win[6][6:0], win[7][6:0], win[8][6:0], win[9][6:0]};
  assign is_start = (word >= 32'h000001b7) && (word <= 32'h000001ef);
  assign is_frame = frame_ok(word);
  assign pos      = cur_r - PB'(LOOKAHEAD_BYTES);
  assign exam_en  = (dec_v_r == mss_pkg::VERDICT_NONE) &&
                    (cur_r >= PB'(LOOKAHEAD_BYTES)) && (pos == next_r);

  always_comb begin
    cur_nxt     = cur_r + PB'(1);
    next_nxt    = next_r;
    miss_nxt    = miss_r;
    dec_v_nxt   = dec_v_r;
    dec_off_nxt = dec_off_r;
    miss_chk    = 1'b0;
    if (exam_en) begin
      priority if (is_id3) begin
        if (bad_size) begin
          dec_v_nxt   = mss_pkg::VERDICT_BAD_ID3;
          dec_off_nxt = pos;
        end else begin
          // skip the tag: size times four plus one
          next_nxt = pos + PB'({size7, 2'b01});
          miss_nxt = MISS_W'(1);
          miss_chk = 1'b1;
        end
      end else if (is_start) begin
        dec_v_nxt   = mss_pkg::VERDICT_START;
        dec_off_nxt = pos;
      end else if (is_frame) begin
        dec_v_nxt   = mss_pkg::VERDICT_MP3;
        dec_off_nxt = pos;
      end else begin
        next_nxt = pos + PB'(1);
        miss_nxt = miss_r + MISS_W'(1);
        miss_chk = 1'b1;
      end
      if (miss_chk && (miss_nxt >= MISS_W'(GARBAGE_LIMIT))) begin
        dec_v_nxt   = mss_pkg::VERDICT_GARBAGE;
        dec_off_nxt = pos;
      end
    end
  end

  assign off_wide = (PB+OW)'(dec_off_nxt);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cur_r     <= '0;
      next_r    <= '0;
      miss_r    <= '0;
      dec_v_r   <= mss_pkg::VERDICT_NONE;
      dec_off_r <= '0;
    end else begin
      if (in_rdy) begin
        in_vld_r <= in_chan.valid;
      end
      if (adv && in_last_r) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
      if (adv) begin
        if (in_last_r) begin
          // end of file: clear for the next one
          cur_r     <= '0;
          next_r    <= '0;
          miss_r    <= '0;
          dec_v_r   <= mss_pkg::VERDICT_NONE;
          dec_off_r <= '0;
        end else begin
          cur_r     <= cur_nxt;
          next_r    <= next_nxt;
          miss_r    <= miss_nxt;
          dec_v_r   <= dec_v_nxt;
          dec_off_r <= dec_off_nxt;
        end
      end
    end
  end

  // Payload: input word, byte window, result word
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_rdy) begin
      in_byte_r <= in_chan.payload.data_byte;
      in_last_r <= in_chan.payload.is_last;
    end
    if (adv) begin
      for (int i = 1; i <= LOOKAHEAD_BYTES; i++) begin
        dl_r[i] <= win[i];
      end
    end
    if (adv && in_last_r) begin
      out_verdict_r <= dec_v_nxt;
      out_off_r     <= (dec_v_nxt == mss_pkg::VERDICT_NONE) ? '0 : off_wide[OW-1:0];
    end
  end

  assign out_chan.valid                   = out_vld_r;
  assign out_chan.payload.verdict         = out_verdict_r;
  assign out_chan.payload.decision_offset = out_off_r;

  // A decided verdict and its offset hold until the file ends.
  a_verdict_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_v_r != mss_pkg::VERDICT_NONE) && !(adv && in_last_r)
      |=> (dec_v_r == $past(dec_v_r)) && (dec_off_r == $past(dec_off_r)))
    else $error("decided verdict changed before end of file");

  // Every state counter clears after the last byte of a file.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_last_r |=> (cur_r == '0) && (miss_r == '0) && (next_r == '0) &&
                         (dec_v_r == mss_pkg::VERDICT_NONE))
    else $error("scan state not cleared after last byte");

  // While undecided, the miss count stays under the garbage limit.
  a_miss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_v_r == mss_pkg::VERDICT_NONE) |-> (miss_r < MISS_W'(GARBAGE_LIMIT)))
    else $error("miss count reached limit without a verdict");

  // A new result only appears after a last byte advanced.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_vld_r) && out_vld_r |-> $past(adv && in_last_r))
    else $error("result word without a last byte");

  // No verdict means no offset.
  a_none_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_verdict_r == mss_pkg::VERDICT_NONE) |-> (out_off_r == '0))
    else $error("offset reported without a verdict");

endmodule

`default_nettype wire

>>> tb/tb_mpeg_stream_sniffer.sv
// Testbench for the MPEG stream sniffer: directed and random files checked against a local predictor.
`timescale 1ns / 100ps

module tb_mpeg_stream_sniffer;

  localparam int LOOKAHEAD   = mss_pkg::LOOKAHEAD_BYTES_DEF;
  localparam int GARBAGE_MAX = mss_pkg::GARBAGE_LIMIT_DEF;
  localparam int POS_W       = mss_pkg::POSITION_BITS_DEF;
  localparam int WIN_LEN     = LOOKAHEAD + 1;

  // Word patterns the sniffer looks for.
  localparam logic [23:0] ID3_TAG      = 24'h494433;
  localparam logic [31:0] SYS_START_LO = 32'h000001B7;
  localparam logic [31:0] SYS_START_HI = 32'h000001EF;
  localparam logic [31:0] MP3_SAMPLE   = 32'hFFFB9000;  // MPEG-1 layer III, 128k, 44.1k

  localparam int MAX_GAP        = 18;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_BYTES    = 800;

  // One file byte as queued for the driver, with flags for the pressure phases.
  typedef struct {
    mss_pkg::in_word_t word;
    bit       tight;        // offer with no gap
    bit       drain_first;  // hold until every verdict is back
    bit       hold_rx;      // ask the receiver for a long hold-off
  } file_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  mss_stream_if #(.word_t(mss_pkg::in_word_t))  in_if ();
  mss_stream_if #(.word_t(mss_pkg::out_word_t)) out_if ();

  mpeg_stream_sniffer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the sniffer's window and counters.
  // ---------------------------------------------------------------------------
  logic [7:0]        win [0:WIN_LEN-1];
  logic [POS_W-1:0]  byte_pos;
  logic [POS_W-1:0]  next_pos;
  int unsigned       missed;
  mss_pkg::verdict_t decided;
  logic [POS_W-1:0]  decided_at;

  mss_pkg::out_word_t verdict_q [$];  // verdicts still owed by the DUT
  int         results_due = 0;   // last bytes accepted (driver side)
  int         results_seen = 0;  // verdicts accepted (receiver side)
  int         fail_cnt = 0;
  int         verdict_tally [0:7];

  task automatic clear_sniffer();
    foreach (win[i]) win[i] = 8'h00;
    byte_pos   = '0;
    next_pos   = '0;
    missed     = 0;
    decided    = mss_pkg::VERDICT_NONE;
    decided_at = '0;
  endtask

  // Advance the predictor by one accepted byte; queue a verdict on the last one.
  task automatic sniff_byte(input mss_pkg::in_word_t w);
    logic [POS_W-1:0]   cur;
    logic [POS_W-1:0]   pos;
    logic [31:0]        head;
    logic [27:0]        tag_size;
    bit                 hdr_ok;
    bit                 size_bad;
    mss_pkg::out_word_t res;
    cur = byte_pos;
    for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
    win[WIN_LEN-1] = w.data_byte;

    // The oldest window byte is the candidate once LOOKAHEAD bytes follow it.
    if (decided == mss_pkg::VERDICT_NONE && cur >= POS_W'(LOOKAHEAD)) begin
      pos = cur - POS_W'(LOOKAHEAD);
      if (pos == next_pos) begin
        head   = {win[0], win[1], win[2], win[3]};
        hdr_ok = (head[31:21] == 11'h7FF) && (head[20:19] != 2'b01) &&
                 (head[18:17] == 2'b01) && (head[15:12] != 4'h0) &&
                 (head[15:12] != 4'hF) && (head[11:10] != 2'b11) &&
                 (head[1:0] != 2'b10);
        if (head[31:8] == ID3_TAG) begin
          size_bad = win[6][7] | win[7][7] | win[8][7] | win[9][7];
          if (size_bad) begin
            decided    = mss_pkg::VERDICT_BAD_ID3;
            decided_at = pos;
          end else begin
            // Skip the tag body: synchsafe size in 4-byte units, plus one.
            tag_size = {win[6][6:0], win[7][6:0], win[8][6:0], win[9][6:0]};
            next_pos = pos + (POS_W'(tag_size) << 2) + POS_W'(1);
            missed   = 1;
          end
        end else if (head >= SYS_START_LO && head <= SYS_START_HI) begin
          decided    = mss_pkg::VERDICT_START;
          decided_at = pos;
        end else if (hdr_ok) begin
          decided    = mss_pkg::VERDICT_MP3;
          decided_at = pos;
        end else begin
          next_pos = pos + POS_W'(1);
          missed++;
        end
        if (decided == mss_pkg::VERDICT_NONE && missed >= GARBAGE_MAX) begin
          decided    = mss_pkg::VERDICT_GARBAGE;
          decided_at = pos;
        end
      end
    end
    byte_pos = cur + POS_W'(1);

    if (w.is_last) begin
      res.verdict         = decided;
      res.decision_offset = (decided == mss_pkg::VERDICT_NONE) ? '0 :
                            mss_pkg::OFFSET_W'(decided_at);
      verdict_q.push_back(res);
      results_due++;
      clear_sniffer();
    end
  endtask

  // ---------------------------------------------------------------------------
  // File builder: bytes collect in file_buf until a file is shipped.
  // ---------------------------------------------------------------------------
  file_byte_t  pending_bytes [$];
  logic [7:0]  file_buf [$];
  int          files_queued = 0;
  int          bytes_queued = 0;

  task automatic put_byte(input logic [7:0] b);
    file_buf.push_back(b);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8]);
  endtask

  task automatic put_rep(input int n, input logic [7:0] b);
    repeat (n) put_byte(b);
  endtask

  task automatic put_noise(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  // Move the collected bytes to the driver queue, last byte marked.
  task automatic ship_file(input bit drain_first, input bit tight, input bit hold_rx);
    file_byte_t fb;
    foreach (file_buf[i]) begin
      fb.word.data_byte = file_buf[i];
      fb.word.is_last   = (i == file_buf.size() - 1);
      fb.tight          = tight;
      fb.drain_first    = drain_first && (i == 0);
      fb.hold_rx        = hold_rx && (i == 0);
      pending_bytes.push_back(fb);
    end
    bytes_queued += file_buf.size();
    files_queued++;
    file_buf.delete();
  endtask

  // Mostly well-formed files (tags, start codes, frame headers) with noise around.
  task automatic queue_random_file();
    int          kind;
    int          lead;
    int          sel;
    int          target;
    logic [7:0]  sz [0:3];
    logic [27:0] tag_size;
    logic [31:0] hdr;
    kind = $urandom_range(0, 49);
    lead = $urandom_range(0, 20);
    if (kind < 6) begin
      put_noise($urandom_range(1, LOOKAHEAD));           // too short to examine
    end else if (kind < 11) begin
      put_noise($urandom_range(LOOKAHEAD + 1, 120));
    end else if (kind < 21) begin
      put_noise(lead);
      case ($urandom_range(0, 5))
        0:       put_word(SYS_START_LO - 32'd1);
        1:       put_word(SYS_START_HI + 32'd1);
        default: put_word($urandom_range(SYS_START_LO, SYS_START_HI));
      endcase
      put_noise($urandom_range(LOOKAHEAD, LOOKAHEAD + 20));
    end else if (kind < 31) begin
      put_noise(lead);
      hdr = $urandom;
      hdr[31:21] = 11'h7FF;
      if ($urandom_range(0, 3) != 0) hdr[18:17] = 2'b01;
      put_word(hdr);
      put_noise($urandom_range(LOOKAHEAD, LOOKAHEAD + 20));
    end else begin
      lead = $urandom_range(0, 6);
      put_noise(lead);
      put_word({ID3_TAG, 8'($urandom)});
      put_noise(2);
      sel = $urandom_range(0, 5);
      foreach (sz[i]) sz[i] = 8'($urandom);
      if (sel == 0) begin
        sz[$urandom_range(0, 3)][7] = 1'b1;             // bad size byte
      end else if (sel == 1) begin
        foreach (sz[i]) sz[i][7] = 1'b0;                // huge skip, past the end
      end else begin
        sz[0] = 8'h00;
        sz[1] = 8'h00;
        sz[2] = 8'h00;
        sz[3] = 8'($urandom_range(0, 12));
      end
      foreach (sz[i]) put_byte(sz[i]);
      if (sel >= 2) begin
        tag_size = {sz[0][6:0], sz[1][6:0], sz[2][6:0], sz[3][6:0]};
        target   = lead + 4 * int'(tag_size) + 1;
        while (file_buf.size() < target) put_noise(1);
        if (file_buf.size() == target) begin
          case ($urandom_range(0, 2))
            0:       put_word(MP3_SAMPLE);
            1:       put_word($urandom_range(SYS_START_LO, SYS_START_HI));
            default: put_word({ID3_TAG, 8'h03});        // nested tag
          endcase
        end
      end
      put_noise($urandom_range(LOOKAHEAD, LOOKAHEAD + 20));
    end
    ship_file($urandom_range(0, 19) == 0, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued bytes with random gaps; predict on each accepted word.
  // ---------------------------------------------------------------------------
  file_byte_t cur_item;
  bit         gap_drawn = 1'b0;
  bit         tx_burst = 1'b0;
  int         tx_gap = 0;
  int         hold_req = 0;
  int         bytes_taken = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_drawn = 1'b0;
      clear_sniffer();
    end else begin
      if (in_if.valid && in_if.ready) begin
        sniff_byte(in_if.payload);
        bytes_taken++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered word until the DUT takes it
      end else if (pending_bytes.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        if (!gap_drawn) begin
          if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
          tx_gap    = (pending_bytes[0].tight || tx_burst) ? 0 : $urandom_range(0, MAX_GAP);
          gap_drawn = 1'b1;
        end
        if (tx_gap > 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_bytes[0].drain_first && results_seen != results_due) begin
          in_if.valid <= 1'b0;   // pause until every verdict is back
        end else begin
          cur_item = pending_bytes.pop_front();
          in_if.valid   <= 1'b1;
          in_if.payload <= cur_item.word;
          if (cur_item.hold_rx) hold_req <= hold_req + 1;
          gap_drawn = 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready stalls, one long hold-off on request; check verdicts.
  // ---------------------------------------------------------------------------
  mss_pkg::out_word_t want;
  bit        rx_burst = 1'b0;
  int        rx_wait = 0;
  int        hold_left = 0;
  int        hold_seen = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        verdict_tally[out_if.payload.verdict]++;
        if (verdict_q.size() == 0) begin
          $error("verdict with none pending: verdict=%0d decision_offset=%0d",
                 out_if.payload.verdict, out_if.payload.decision_offset);
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (out_if.payload.verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict,
                   out_if.payload.verdict);
            fail_cnt++;
          end
          if (out_if.payload.decision_offset !== want.decision_offset) begin
            $error("decision_offset: expected %0d, actual %0d", want.decision_offset,
                   out_if.payload.decision_offset);
            fail_cnt++;
          end
        end
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    out_if.ready  = 1'b0;
    foreach (verdict_tally[i]) verdict_tally[i] = 0;

    // single-byte file, then a start code in a file one byte too short
    put_byte(8'hFF);
    ship_file(1'b0, 1'b0, 1'b0);
    put_word(SYS_START_LO);
    put_rep(LOOKAHEAD - 4, 8'h00);
    ship_file(1'b0, 1'b0, 1'b0);

    // shortest examined file: start code at offset 0
    put_word(SYS_START_LO);
    put_rep(LOOKAHEAD - 3, 8'h00);
    ship_file(1'b0, 1'b0, 1'b0);

    // top of the start-code range after three misses
    put_rep(3, 8'h00);
    put_word(SYS_START_HI);
    put_rep(LOOKAHEAD, 8'h00);
    ship_file(1'b0, 1'b0, 1'b0);

    // codes just outside the range, then a valid frame header
    put_word(SYS_START_LO - 32'd1);
    put_word(SYS_START_HI + 32'd1);
    put_word(MP3_SAMPLE);
    put_rep(LOOKAHEAD, 8'h00);
    ship_file(1'b0, 1'b0, 1'b0);

    // each broken header field in turn: version, layer, bitrate 0 and 15,
    // sampling index, emphasis; then a good header
    put_word(32'hFFEB9000);
    put_word(32'hFFFD9000);
    put_word(32'hFFFB0000);
    put_word(32'hFFFBF000);
    put_word(32'hFFFB9C00);
    put_word(32'hFFFB9002);
    put_word(MP3_SAMPLE);
    put_rep(LOOKAHEAD, 8'h00);
    ship_file(1'b0, 1'b0, 1'b0);

    // ID3 tag of size 3 skips to offset 13, where a start code sits
    put_word({ID3_TAG, 8'h04});
    put_rep(5, 8'h00);
    put_byte(8'h03);
    put_rep(3, 8'h00);
    put_word(32'h000001BA);
    put_rep(LOOKAHEAD, 8'h00);
    ship_file(1'b0, 1'b0, 1'b0);

    // ID3 tag at offset 2 with a size byte of 0x80
    put_rep(2, 8'h00);
    put_word({ID3_TAG, 8'h03});
    put_rep(4, 8'h00);
    put_byte(8'h80);
    put_byte(8'h00);
    put_rep(LOOKAHEAD, 8'h00);
    ship_file(1'b0, 1'b0, 1'b0);

    // largest tag size: the skip lands past the end of the file
    put_word({ID3_TAG, 8'hFF});
    put_rep(2, 8'hFF);
    put_rep(4, 8'h7F);
    put_rep(LOOKAHEAD, 8'hFF);
    ship_file(1'b0, 1'b0, 1'b0);

    // back-pressure: long receiver hold while one-byte files stream in,
    // then a file that waits for every verdict before it starts
    put_byte(8'h00);
    ship_file(1'b0, 1'b1, 1'b1);
    repeat (24) begin
      put_noise(1);
      ship_file(1'b0, 1'b1, 1'b0);
    end
    put_word(SYS_START_HI);
    put_noise(LOOKAHEAD);
    ship_file(1'b1, 1'b0, 1'b0);

    // random files until the run holds enough bytes
    while (bytes_queued < TOTAL_BYTES) queue_random_file();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // sample between edges so the driver and receiver updates have settled
    while (pending_bytes.size() != 0 || in_if.valid || results_seen != results_due)
      @(negedge clk);
    repeat (8) @(posedge clk);

    if (verdict_q.size() != 0) begin
      $error("%0d verdicts never arrived", verdict_q.size());
      fail_cnt++;
    end
    $display("Ran %0d files, %0d bytes through the sniffer with random stalls on both sides.",
             files_queued, bytes_taken);
    $display("Verdicts none/bad-ID3/garbage/start-code/mp3: %0d/%0d/%0d/%0d/%0d",
             verdict_tally[mss_pkg::VERDICT_NONE], verdict_tally[mss_pkg::VERDICT_BAD_ID3],
             verdict_tally[mss_pkg::VERDICT_GARBAGE], verdict_tally[mss_pkg::VERDICT_START],
             verdict_tally[mss_pkg::VERDICT_MP3]);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
